[rtl/mts_pkg.sv]
// Shared types and constants for the min-tracking stack.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam int S_FIELDS_W = OP_W + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STATUS_W + VALUE_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam int CAPACITY_RESET = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_ENABLE = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TOP  = 2'd2,
        OP_MIN  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_NO_MIN    = 2'd3
    } outcome_t;

    typedef enum logic {
        ST_RUN,
        ST_REFILL
    } state_t;

endpackage

`default_nettype wire

[rtl/mts_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/min_tracking_stack_top.sv]
// Min-tracking stack: bounded LIFO with a companion stack of minima.
//
// Requests enter on the s_ group (op, push_value) and each returns one item
// on the m_ group (status, read_value, item_count). Registers are written on
// the cfg_ channel: index 0 capacity_limit, index 1 min_enable; cfg_ready is
// always high. Write configuration only while no request is in flight.
//
// The current top of each stack sits in a register; the entries beneath it
// live in two synchronous RAMs. Push, top and min requests need no refill,
// so one can be accepted every cycle while the output queue has room. A pop
// that leaves a popped stack non-empty refills its top, which comes back
// from RAM in the next cycle; s_tready is low in the ST_REFILL state.
//
// With the output queue empty the result is valid on m_ the cycle after the
// request is taken. A two-entry queue holds results while m_tready is low;
// the block keeps accepting until both entries are full, then drops s_tready.
//
// Reset empties both stacks, sets capacity_limit to 64 and enables min
// tracking. No clearing pass: RAM data is only used after being written.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack_top #(
    parameter int DEPTH      = mts_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mts_pkg::S_TDATA_W-1:0]  s_tdata,    // op, push_value
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mts_pkg::M_TDATA_W-1:0]  m_tdata,    // status, read_value, item_count
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mts_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mts_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        item_fill_reg, item_fill_next;
    logic [CNT_W-1:0]        min_fill_reg, min_fill_next;
    logic [DATA_WIDTH-1:0]   top_reg, top_next;
    logic [DATA_WIDTH-1:0]   min_top_reg, min_top_next;
    logic                    refill_item_reg, refill_item_next;
    logic                    refill_min_reg, refill_min_next;
    logic [COUNT_W-1:0]      cap_reg, cap_next;
    logic                    min_en_reg, min_en_next;

    logic [M_TDATA_W-1:0]    q0_reg, q0_next;
    logic [M_TDATA_W-1:0]    q1_reg, q1_next;
    logic                    v0_reg, v0_next;
    logic                    v1_reg, v1_next;

    op_t                     op;
    logic [DATA_WIDTH-1:0]   in_value;
    logic                    accept;
    logic                    deq;
    logic [CMP_W-1:0]        cap_ext;
    logic [CMP_W-1:0]        eff_cap;
    logic                    full;
    logic                    empty;
    logic                    min_empty;
    logic                    min_full;
    outcome_t                status;
    logic [DATA_WIDTH-1:0]   rd_value;
    logic [M_TDATA_W-1:0]    result;

    logic                    item_wr_en, min_wr_en;
    logic                    item_rd_en, min_rd_en;
    logic [AW-1:0]           item_wr_addr, item_rd_addr;
    logic [AW-1:0]           min_wr_addr, min_rd_addr;
    logic [DATA_WIDTH-1:0]   item_rd_data, min_rd_data;

    mts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (item_wr_en),
        .wr_addr (item_wr_addr),
        .wr_data (top_reg),
        .rd_en   (item_rd_en),
        .rd_addr (item_rd_addr),
        .rd_data (item_rd_data)
    );

    mts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_min_ram (
        .clk     (clk),
        .wr_en   (min_wr_en),
        .wr_addr (min_wr_addr),
        .wr_data (min_top_reg),
        .rd_en   (min_rd_en),
        .rd_addr (min_rd_addr),
        .rd_data (min_rd_data)
    );

    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign in_value = DATA_WIDTH'(s_tdata[OP_W +: VALUE_W]);
    assign accept   = s_tvalid && s_tready;
    assign deq      = v0_reg && m_tready;

    // capacity of zero acts as one, above DEPTH saturates
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full      = CMP_W'(item_fill_reg) >= eff_cap;
    assign empty     = (item_fill_reg == '0);
    assign min_empty = (min_fill_reg == '0);
    assign min_full  = (min_fill_reg == CNT_W'(DEPTH));

    // entry below the top: old top goes to fill-1, new top comes from fill-2
    assign item_wr_addr = AW'(item_fill_reg - CNT_W'(1));
    assign item_rd_addr = AW'(item_fill_reg - CNT_W'(2));
    assign min_wr_addr  = AW'(min_fill_reg - CNT_W'(1));
    assign min_rd_addr  = AW'(min_fill_reg - CNT_W'(2));

    always_comb
    begin
        item_fill_next   = item_fill_reg;
        min_fill_next    = min_fill_reg;
        top_next         = top_reg;
        min_top_next     = min_top_reg;
        refill_item_next = refill_item_reg;
        refill_min_next  = refill_min_reg;
        item_wr_en       = 1'b0;
        min_wr_en        = 1'b0;
        item_rd_en       = 1'b0;
        min_rd_en        = 1'b0;
        status           = STAT_OK;
        rd_value         = '0;

        if (state_reg == ST_REFILL)
        begin
            if (refill_item_reg)
            begin
                top_next = item_rd_data;
            end
            if (refill_min_reg)
            begin
                min_top_next = min_rd_data;
            end
            refill_item_next = 1'b0;
            refill_min_next  = 1'b0;
        end

        if (accept)
        begin
            unique case (op)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        status = STAT_OVERFLOW;
                    end
                    else
                    begin
                        item_wr_en     = !empty;
                        top_next       = in_value;
                        item_fill_next = item_fill_reg + CNT_W'(1);
                        if (min_en_reg && !min_full &&
                            (min_empty || in_value <= min_top_reg))
                        begin
                            min_wr_en     = !min_empty;
                            min_top_next  = in_value;
                            min_fill_next = min_fill_reg + CNT_W'(1);
                        end
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        status = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        rd_value         = top_reg;
                        item_fill_next   = item_fill_reg - CNT_W'(1);
                        item_rd_en       = 1'b1;
                        refill_item_next = item_fill_reg >= CNT_W'(2);
                        if (min_en_reg && !min_empty && min_top_reg == top_reg)
                        begin
                            min_fill_next   = min_fill_reg - CNT_W'(1);
                            min_rd_en       = 1'b1;
                            refill_min_next = min_fill_reg >= CNT_W'(2);
                        end
                    end
                end
                OP_TOP:
                begin
                    if (empty)
                    begin
                        status = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        rd_value = top_reg;
                    end
                end
                OP_MIN:
                begin
                    if (!min_en_reg)
                    begin
                        status = STAT_NO_MIN;
                    end
                    else if (empty || min_empty)
                    begin
                        status = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        rd_value = min_top_reg;
                    end
                end
                default:
                begin
                    status = STAT_OK;
                end
            endcase
        end
    end

    assign result = M_TDATA_W'({COUNT_W'(item_fill_next), VALUE_W'(rd_value), status});

    // next state
    always_comb
    begin
        unique case (state_reg)
            ST_RUN:
            begin
                state_next = (refill_item_next || refill_min_next) ? ST_REFILL : ST_RUN;
            end
            ST_REFILL:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        unique case (state_reg)
            ST_RUN:
            begin
                s_tready = !v1_reg;
            end
            ST_REFILL:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // two-entry output queue, q0 is the head
    always_comb
    begin
        q0_next = q0_reg;
        q1_next = q1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (deq)
        begin
            if (v1_reg)
            begin
                q0_next = q1_reg;
                if (accept)
                begin
                    q1_next = result;
                end
                else
                begin
                    v1_next = 1'b0;
                end
            end
            else if (accept)
            begin
                q0_next = result;
            end
            else
            begin
                v0_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!v0_reg)
            begin
                q0_next = result;
                v0_next = 1'b1;
            end
            else
            begin
                q1_next = result;
                v1_next = 1'b1;
            end
        end
    end

    assign m_tvalid  = v0_reg;
    assign m_tdata   = q0_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cap_next    = cap_reg;
        min_en_next = min_en_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAPACITY:   cap_next    = cfg_data;
                REG_MIN_ENABLE: min_en_next = cfg_data[0];
                default:        cap_next    = cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            item_fill_reg   <= '0;
            min_fill_reg    <= '0;
            refill_item_reg <= 1'b0;
            refill_min_reg  <= 1'b0;
            cap_reg         <= COUNT_W'(CAPACITY_RESET);
            min_en_reg      <= 1'b1;
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            item_fill_reg   <= item_fill_next;
            min_fill_reg    <= min_fill_next;
            refill_item_reg <= refill_item_next;
            refill_min_reg  <= refill_min_next;
            cap_reg         <= cap_next;
            min_en_reg      <= min_en_next;
            v0_reg          <= v0_next;
            v1_reg          <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        min_top_reg <= min_top_next;
        q0_reg      <= q0_next;
        q1_reg      <= q1_next;
    end

endmodule

`default_nettype wire

[rtl/mts_checker.sv]
// Port-level checks for the min-tracking stack, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mts_checker #(
    parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [mts_pkg::M_TDATA_W-1:0]   m_tdata
);

    import mts_pkg::*;

    logic [STATUS_W-1:0] m_status;
    logic [VALUE_W-1:0]  m_value;
    logic [COUNT_W-1:0]  m_count;

    assign m_status = m_tdata[STATUS_W-1:0];
    assign m_value  = m_tdata[STATUS_W +: VALUE_W];
    assign m_count  = m_tdata[STATUS_W + VALUE_W +: COUNT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result the cycle after a request");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_status != STAT_OK |-> m_value == '0)
        else $error("failed request returned a nonzero value");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_count) <= 32'(DEPTH))
        else $error("item count above depth");

    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid && !m_tready |=> !s_tready)
        else $error("request taken with output queue full");

endmodule

bind min_tracking_stack_top mts_checker #(.DEPTH(DEPTH)) u_mts_checker (.*);

`default_nettype wire
